FILE: rtl/pmpd_pkg.sv
// Shared types and constants for the PS/2 mouse packet decoder.
package pmpd_pkg;

    localparam int COORD_BITS_DEFAULT   = 13;
    localparam int COUNTER_BITS_DEFAULT = 32;
    localparam int SIZE_BITS            = 14;
    localparam int QUEUE_DEPTH          = 2;

    localparam logic [SIZE_BITS-1:0] WIDTH_RESET  = 14'd800;
    localparam logic [SIZE_BITS-1:0] HEIGHT_RESET = 14'd600;
    localparam int CURSOR_X_RESET = 800 / 2;
    localparam int CURSOR_Y_RESET = 600 / 2;

    localparam logic REG_SCREEN_WIDTH  = 1'b0;
    localparam logic REG_SCREEN_HEIGHT = 1'b1;

    localparam logic [7:0] SYNC_MASK     = 8'h08;
    localparam logic [7:0] OVERFLOW_MASK = 8'hC0;

    typedef enum logic [2:0] {
        EV_NO_DATA   = 3'd0,
        EV_DRAINED   = 3'd1,
        EV_SYNC_LOSS = 3'd2,
        EV_STORED    = 3'd3,
        EV_OVF_DROP  = 3'd4,
        EV_SIGN_DROP = 3'd5,
        EV_MOVED     = 3'd6
    } event_code_t;

    typedef struct packed {
        event_code_t code;
        logic [8:0]  dx;
        logic [8:0]  dy;
        logic [2:0]  buttons;
    } cmd_t;

endpackage

FILE: rtl/pmpd_front.sv
// Front end: accepts controller read beats, assembles packets and classifies each beat.
module pmpd_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            output_full,
    input  logic            from_aux,
    input  logic [7:0]      data_byte,
    output logic            push_valid,
    input  logic            push_ready,
    output pmpd_pkg::cmd_t  push_cmd
);

    logic [1:0]     pos_reg;
    logic [1:0]     pos_next;
    logic [7:0]     pkt_reg [2];
    logic           store_en;
    logic           accept;
    pmpd_pkg::cmd_t cmd;
    logic [7:0]     flags;
    logic [7:0]     mx;

    assign in_ready   = push_ready;
    assign accept     = in_valid && push_ready;
    assign push_valid = in_valid;
    assign push_cmd   = cmd;
    assign flags      = pkt_reg[0];
    assign mx         = pkt_reg[1];

    always_comb
    begin
        pos_next    = pos_reg;
        store_en    = 1'b0;
        cmd.code    = pmpd_pkg::EV_NO_DATA;
        cmd.dx      = {flags[4], mx};
        cmd.dy      = {flags[5], data_byte};
        cmd.buttons = flags[2:0];
        if (!output_full)
        begin
            cmd.code = pmpd_pkg::EV_NO_DATA;
        end
        else if (!from_aux)
        begin
            cmd.code = pmpd_pkg::EV_DRAINED;
        end
        else if (pos_reg == 2'd0 && (data_byte & pmpd_pkg::SYNC_MASK) == 8'h00)
        begin
            cmd.code = pmpd_pkg::EV_SYNC_LOSS;
        end
        else if (pos_reg != 2'd2)
        begin
            cmd.code = pmpd_pkg::EV_STORED;
            store_en = 1'b1;
            pos_next = pos_reg + 2'd1;
        end
        else
        begin
            pos_next = 2'd0;
            if ((flags & pmpd_pkg::OVERFLOW_MASK) != 8'h00)
            begin
                cmd.code = pmpd_pkg::EV_OVF_DROP;
            end
            else if (flags[4] != mx[7] || flags[5] != data_byte[7])
            begin
                cmd.code = pmpd_pkg::EV_SIGN_DROP;
            end
            else
            begin
                cmd.code = pmpd_pkg::EV_MOVED;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= 2'd0;
        end
        else if (accept)
        begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && store_en)
        begin
            pkt_reg[pos_reg[0]] <= data_byte;
        end
    end

`ifndef SYNTHESIS
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg != 2'd3)
        else $error("byte position out of range");
    a_third_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && output_full && from_aux && pos_reg == 2'd2 |=> pos_reg == 2'd0)
        else $error("third byte did not close the packet");
    a_hold_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> pos_reg == $past(pos_reg))
        else $error("byte position moved without a beat");
`endif

endmodule

FILE: rtl/pmpd_queue.sv
// Short command queue between the front end and the back end.
module pmpd_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  pmpd_pkg::cmd_t  push_cmd,
    output logic            pop_valid,
    input  logic            pop_ready,
    output pmpd_pkg::cmd_t  pop_cmd
);

    localparam int DEPTH = pmpd_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    pmpd_pkg::cmd_t entry_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic           push;
    logic           pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_cmd    = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

`ifndef SYNTHESIS
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");
    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + CW'(1))
        else $error("queue count missed a push");
    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 |-> !pop)
        else $error("pop from empty queue");
`endif

endmodule

FILE: rtl/pmpd_back.sv
// Back end: applies classified commands to cursor, buttons and counters, holds the result.
module pmpd_back
#(
    parameter int COORD_BITS   = pmpd_pkg::COORD_BITS_DEFAULT,
    parameter int COUNTER_BITS = pmpd_pkg::COUNTER_BITS_DEFAULT
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [pmpd_pkg::SIZE_BITS-1:0]    cfg_data,
    input  logic                              pop_valid,
    output logic                              pop_ready,
    input  pmpd_pkg::cmd_t                    pop_cmd,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [COORD_BITS-1:0]             cursor_x,
    output logic [COORD_BITS-1:0]             cursor_y,
    output logic [2:0]                        button_bits,
    output logic [2:0]                        event_code,
    output logic [COUNTER_BITS-1:0]           packet_count,
    output logic [COUNTER_BITS-1:0]           dropped_count,
    output logic [COUNTER_BITS-1:0]           aux_byte_count,
    output logic [COUNTER_BITS-1:0]           sync_loss_count,
    output logic [COUNTER_BITS-1:0]           drained_count
);

    localparam int SB = pmpd_pkg::SIZE_BITS;
    localparam int CW = ((COORD_BITS > SB) ? COORD_BITS : SB) + 2;

    logic [SB-1:0]           width_reg;
    logic [SB-1:0]           height_reg;
    logic                    valid_reg;
    logic [COORD_BITS-1:0]   x_reg;
    logic [COORD_BITS-1:0]   x_next;
    logic [COORD_BITS-1:0]   y_reg;
    logic [COORD_BITS-1:0]   y_next;
    logic [2:0]              btn_reg;
    pmpd_pkg::event_code_t   code_reg;
    logic [COUNTER_BITS-1:0] pkt_cnt_reg;
    logic [COUNTER_BITS-1:0] drop_cnt_reg;
    logic [COUNTER_BITS-1:0] aux_cnt_reg;
    logic [COUNTER_BITS-1:0] sync_cnt_reg;
    logic [COUNTER_BITS-1:0] drain_cnt_reg;
    logic                    pop;
    logic [CW-1:0]           cmax;
    logic [CW-1:0]           lim_x;
    logic [CW-1:0]           lim_y;
    logic signed [CW-1:0]    vx;
    logic signed [CW-1:0]    vy;
    logic                    is_aux;
    logic                    is_drop;

    assign pop       = pop_valid && (!valid_reg || out_ready);
    assign pop_ready = !valid_reg || out_ready;

    assign cmax = (CW'(1) << COORD_BITS) - CW'(1);

    always_comb
    begin
        lim_x = (width_reg == '0) ? '0 : CW'(width_reg) - CW'(1);
        if (lim_x > cmax)
        begin
            lim_x = cmax;
        end
        lim_y = (height_reg == '0) ? '0 : CW'(height_reg) - CW'(1);
        if (lim_y > cmax)
        begin
            lim_y = cmax;
        end
    end

    always_comb
    begin
        vx = $signed(CW'(x_reg)) + $signed({{(CW-9){pop_cmd.dx[8]}}, pop_cmd.dx});
        vy = $signed(CW'(y_reg)) - $signed({{(CW-9){pop_cmd.dy[8]}}, pop_cmd.dy});
        if (vx[CW-1])
        begin
            x_next = '0;
        end
        else if (CW'(vx) > lim_x)
        begin
            x_next = lim_x[COORD_BITS-1:0];
        end
        else
        begin
            x_next = vx[COORD_BITS-1:0];
        end
        if (vy[CW-1])
        begin
            y_next = '0;
        end
        else if (CW'(vy) > lim_y)
        begin
            y_next = lim_y[COORD_BITS-1:0];
        end
        else
        begin
            y_next = vy[COORD_BITS-1:0];
        end
    end

    assign is_aux  = (pop_cmd.code != pmpd_pkg::EV_NO_DATA) &&
                     (pop_cmd.code != pmpd_pkg::EV_DRAINED);
    assign is_drop = (pop_cmd.code == pmpd_pkg::EV_OVF_DROP) ||
                     (pop_cmd.code == pmpd_pkg::EV_SIGN_DROP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= pmpd_pkg::WIDTH_RESET;
            height_reg <= pmpd_pkg::HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pmpd_pkg::REG_SCREEN_WIDTH:  width_reg  <= cfg_data;
                pmpd_pkg::REG_SCREEN_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            x_reg         <= COORD_BITS'(pmpd_pkg::CURSOR_X_RESET);
            y_reg         <= COORD_BITS'(pmpd_pkg::CURSOR_Y_RESET);
            btn_reg       <= 3'd0;
            code_reg      <= pmpd_pkg::EV_NO_DATA;
            pkt_cnt_reg   <= '0;
            drop_cnt_reg  <= '0;
            aux_cnt_reg   <= '0;
            sync_cnt_reg  <= '0;
            drain_cnt_reg <= '0;
        end
        else
        begin
            if (pop)
            begin
                valid_reg <= 1'b1;
                code_reg  <= pop_cmd.code;
                if (is_aux)
                begin
                    aux_cnt_reg <= aux_cnt_reg + COUNTER_BITS'(1);
                end
                if (is_drop)
                begin
                    drop_cnt_reg <= drop_cnt_reg + COUNTER_BITS'(1);
                end
                case (pop_cmd.code)
                    pmpd_pkg::EV_DRAINED:
                    begin
                        drain_cnt_reg <= drain_cnt_reg + COUNTER_BITS'(1);
                    end
                    pmpd_pkg::EV_SYNC_LOSS:
                    begin
                        sync_cnt_reg <= sync_cnt_reg + COUNTER_BITS'(1);
                    end
                    pmpd_pkg::EV_MOVED:
                    begin
                        x_reg       <= x_next;
                        y_reg       <= y_next;
                        btn_reg     <= pop_cmd.buttons;
                        pkt_cnt_reg <= pkt_cnt_reg + COUNTER_BITS'(1);
                    end
                    default: ;
                endcase
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid       = valid_reg;
    assign cursor_x        = x_reg;
    assign cursor_y        = y_reg;
    assign button_bits     = btn_reg;
    assign event_code      = code_reg;
    assign packet_count    = pkt_cnt_reg;
    assign dropped_count   = drop_cnt_reg;
    assign aux_byte_count  = aux_cnt_reg;
    assign sync_loss_count = sync_cnt_reg;
    assign drained_count   = drain_cnt_reg;

`ifndef SYNTHESIS
    a_pop_shows: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> valid_reg)
        else $error("popped command produced no result");
    a_move_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        pop && pop_cmd.code == pmpd_pkg::EV_MOVED |=>
            CW'(x_reg) <= lim_x && CW'(y_reg) <= lim_y)
        else $error("cursor outside the screen after a move");
    a_aux_count: assert property (@(posedge clk) disable iff (!rst_n)
        pop && is_aux |=> aux_cnt_reg == $past(aux_cnt_reg) + COUNTER_BITS'(1))
        else $error("auxiliary byte not counted");
    a_cursor_only_on_move: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && pop_cmd.code == pmpd_pkg::EV_MOVED) |=> $stable(x_reg) && $stable(y_reg))
        else $error("cursor moved without an accepted packet");
`endif

endmodule

FILE: rtl/ps2_mouse_packet_decoder.sv
// Top level of the PS/2 mouse three-byte packet decoder.
// Takes one controller read beat per cycle unless back-pressure from out_ready fills
// the queue, and returns exactly one result beat for each, in order: the cursor clamped
// to the screen, the latched buttons, an event code and five wrapping counters. Each
// beat is written into the command queue, then registered into the result by the back
// end, which applies it with a single add-and-clamp per axis. A two-entry command queue
// lets the input keep flowing while a result waits to be taken. Screen size writes take
// effect on the next packet and do not move the cursor by themselves.
module ps2_mouse_packet_decoder
#(
    parameter int COORD_BITS   = pmpd_pkg::COORD_BITS_DEFAULT,
    parameter int COUNTER_BITS = pmpd_pkg::COUNTER_BITS_DEFAULT
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [pmpd_pkg::SIZE_BITS-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           output_full,
    input  logic                           from_aux,
    input  logic [7:0]                     data_byte,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [COORD_BITS-1:0]          cursor_x,
    output logic [COORD_BITS-1:0]          cursor_y,
    output logic [2:0]                     button_bits,
    output logic [2:0]                     event_code,
    output logic [COUNTER_BITS-1:0]        packet_count,
    output logic [COUNTER_BITS-1:0]        dropped_count,
    output logic [COUNTER_BITS-1:0]        aux_byte_count,
    output logic [COUNTER_BITS-1:0]        sync_loss_count,
    output logic [COUNTER_BITS-1:0]        drained_count
);

    logic           push_valid;
    logic           push_ready;
    pmpd_pkg::cmd_t push_cmd;
    logic           pop_valid;
    logic           pop_ready;
    pmpd_pkg::cmd_t pop_cmd;

    pmpd_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .output_full (output_full),
        .from_aux    (from_aux),
        .data_byte   (data_byte),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_cmd    (push_cmd)
    );

    pmpd_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    pmpd_back
    #(
        .COORD_BITS   (COORD_BITS),
        .COUNTER_BITS (COUNTER_BITS)
    )
    u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .pop_valid       (pop_valid),
        .pop_ready       (pop_ready),
        .pop_cmd         (pop_cmd),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .cursor_x        (cursor_x),
        .cursor_y        (cursor_y),
        .button_bits     (button_bits),
        .event_code      (event_code),
        .packet_count    (packet_count),
        .dropped_count   (dropped_count),
        .aux_byte_count  (aux_byte_count),
        .sync_loss_count (sync_loss_count),
        .drained_count   (drained_count)
    );

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for the PS/2 mouse packet decoder, with a cycle-free predictor.
`timescale 1ns / 1ps

module tb;

    localparam int COORD_BITS = pmpd_pkg::COORD_BITS_DEFAULT;
    localparam int COUNT_BITS = pmpd_pkg::COUNTER_BITS_DEFAULT;
    localparam int SIZE_BITS  = pmpd_pkg::SIZE_BITS;
    localparam int COORD_MAX  = (1 << COORD_BITS) - 1;
    localparam int N_DIRECTED = 25;

    typedef struct packed {
        logic                  full;
        logic                  aux;
        logic [7:0]            data;
        logic                  pinned;
        pmpd_pkg::event_code_t pinned_code;
    } ctrl_read_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] col;
        logic [COORD_BITS-1:0] row;
        logic [2:0]            buttons;
        pmpd_pkg::event_code_t code;
        logic [COUNT_BITS-1:0] packets;
        logic [COUNT_BITS-1:0] dropped;
        logic [COUNT_BITS-1:0] aux_bytes;
        logic [COUNT_BITS-1:0] sync_misses;
        logic [COUNT_BITS-1:0] drained;
    } cursor_report_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic                  cfg_index = pmpd_pkg::REG_SCREEN_WIDTH;
    logic [SIZE_BITS-1:0]  cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  output_full = 1'b0;
    logic                  from_aux = 1'b0;
    logic [7:0]            data_byte = 8'h00;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [COORD_BITS-1:0] cursor_x;
    logic [COORD_BITS-1:0] cursor_y;
    logic [2:0]            button_bits;
    logic [2:0]            event_code;
    logic [COUNT_BITS-1:0] packet_count;
    logic [COUNT_BITS-1:0] dropped_count;
    logic [COUNT_BITS-1:0] aux_byte_count;
    logic [COUNT_BITS-1:0] sync_loss_count;
    logic [COUNT_BITS-1:0] drained_count;

    // Predictor state.
    logic [SIZE_BITS-1:0]  scr_width;
    logic [SIZE_BITS-1:0]  scr_height;
    logic [1:0]            byte_slot;
    logic [7:0]            held_bytes [2];
    logic [COORD_BITS-1:0] cur_col;
    logic [COORD_BITS-1:0] cur_row;
    logic [2:0]            held_buttons;
    logic [COUNT_BITS-1:0] n_packets;
    logic [COUNT_BITS-1:0] n_dropped;
    logic [COUNT_BITS-1:0] n_aux;
    logic [COUNT_BITS-1:0] n_sync;
    logic [COUNT_BITS-1:0] n_drained;

    ctrl_read_t            pending_reads [$];
    cursor_report_t        reports_due [$];
    ctrl_read_t            directed_reads [N_DIRECTED];
    ctrl_read_t            in_flight;
    cursor_report_t        predicted;
    cursor_report_t        want;

    int                    results_due = 0;
    int                    results_checked = 0;
    int                    full_reads = 0;
    int                    mismatches = 0;
    int                    gap_left = 0;
    int                    stall_left = 0;
    bit                    quiet = 1'b0;

    ps2_mouse_packet_decoder uut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .output_full     (output_full),
        .from_aux        (from_aux),
        .data_byte       (data_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .cursor_x        (cursor_x),
        .cursor_y        (cursor_y),
        .button_bits     (button_bits),
        .event_code      (event_code),
        .packet_count    (packet_count),
        .dropped_count   (dropped_count),
        .aux_byte_count  (aux_byte_count),
        .sync_loss_count (sync_loss_count),
        .drained_count   (drained_count)
    );

    always #1 clk = ~clk;

    function automatic logic [COORD_BITS-1:0] clamp_coord(input int v,
                                                          input logic [SIZE_BITS-1:0] size);
        int lim;
        lim = int'(size);
        if (lim > 0)
        begin
            lim--;
        end
        if (lim > COORD_MAX)
        begin
            lim = COORD_MAX;
        end
        if (v < 0)
        begin
            return '0;
        end
        if (v > lim)
        begin
            return lim[COORD_BITS-1:0];
        end
        return v[COORD_BITS-1:0];
    endfunction

    function automatic cursor_report_t decode_read(input logic full, input logic aux,
                                                   input logic [7:0] b);
        cursor_report_t        r;
        pmpd_pkg::event_code_t ev;
        int                    dx;
        int                    dy;
        int                    c;
        ev = pmpd_pkg::EV_NO_DATA;
        if (full)
        begin
            if (!aux)
            begin
                n_drained++;
                ev = pmpd_pkg::EV_DRAINED;
            end
            else
            begin
                n_aux++;
                if (byte_slot == 2'd0 && !b[3])
                begin
                    n_sync++;
                    ev = pmpd_pkg::EV_SYNC_LOSS;
                end
                else if (byte_slot < 2'd2)
                begin
                    held_bytes[byte_slot] = b;
                    byte_slot++;
                    ev = pmpd_pkg::EV_STORED;
                end
                else
                begin
                    byte_slot = 2'd0;
                    if (held_bytes[0][7:6] != 2'b00)
                    begin
                        n_dropped++;
                        ev = pmpd_pkg::EV_OVF_DROP;
                    end
                    else if (held_bytes[0][4] != held_bytes[1][7] || held_bytes[0][5] != b[7])
                    begin
                        n_dropped++;
                        ev = pmpd_pkg::EV_SIGN_DROP;
                    end
                    else
                    begin
                        dx = int'(held_bytes[1]);
                        dy = int'(b);
                        if (held_bytes[0][4])
                        begin
                            dx -= 256;
                        end
                        if (held_bytes[0][5])
                        begin
                            dy -= 256;
                        end
                        c = int'(cur_col);
                        cur_col = clamp_coord(c + dx, scr_width);
                        c = int'(cur_row);
                        cur_row = clamp_coord(c - dy, scr_height);
                        held_buttons = held_bytes[0][2:0];
                        n_packets++;
                        ev = pmpd_pkg::EV_MOVED;
                    end
                end
            end
        end
        r.col         = cur_col;
        r.row         = cur_row;
        r.buttons     = held_buttons;
        r.code        = ev;
        r.packets     = n_packets;
        r.dropped     = n_dropped;
        r.aux_bytes   = n_aux;
        r.sync_misses = n_sync;
        r.drained     = n_drained;
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            predicted = decode_read(in_flight.full, in_flight.aux, in_flight.data);
            if (in_flight.pinned)
            begin
                predicted.code = in_flight.pinned_code;
            end
            reports_due.push_back(predicted);
        end
        if (!in_valid || in_ready)
        begin
            if (gap_left > 0 && !quiet)
            begin
                in_valid <= 1'b0;
                gap_left--;
            end
            else if (rst_n && pending_reads.size() > 0)
            begin
                in_flight = pending_reads.pop_front();
                output_full <= in_flight.full;
                from_aux    <= in_flight.aux;
                data_byte   <= in_flight.data;
                in_valid    <= 1'b1;
                if (!quiet && $urandom_range(0, 7) == 0)
                begin
                    gap_left = $urandom_range(1, 10);
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            if (reports_due.size() == 0)
            begin
                $error("unexpected result beat: event_code %0d", event_code);
                mismatches++;
            end
            else
            begin
                want = reports_due.pop_front();
                if (cursor_x !== want.col)
                begin
                    $error("cursor_x: expected %0d, got %0d", want.col, cursor_x);
                    mismatches++;
                end
                if (cursor_y !== want.row)
                begin
                    $error("cursor_y: expected %0d, got %0d", want.row, cursor_y);
                    mismatches++;
                end
                if (button_bits !== want.buttons)
                begin
                    $error("button_bits: expected %0d, got %0d", want.buttons, button_bits);
                    mismatches++;
                end
                if (event_code !== want.code)
                begin
                    $error("event_code: expected %0d, got %0d", want.code, event_code);
                    mismatches++;
                end
                if (packet_count !== want.packets)
                begin
                    $error("packet_count: expected %0d, got %0d", want.packets, packet_count);
                    mismatches++;
                end
                if (dropped_count !== want.dropped)
                begin
                    $error("dropped_count: expected %0d, got %0d", want.dropped, dropped_count);
                    mismatches++;
                end
                if (aux_byte_count !== want.aux_bytes)
                begin
                    $error("aux_byte_count: expected %0d, got %0d", want.aux_bytes,
                           aux_byte_count);
                    mismatches++;
                end
                if (sync_loss_count !== want.sync_misses)
                begin
                    $error("sync_loss_count: expected %0d, got %0d", want.sync_misses,
                           sync_loss_count);
                    mismatches++;
                end
                if (drained_count !== want.drained)
                begin
                    $error("drained_count: expected %0d, got %0d", want.drained, drained_count);
                    mismatches++;
                end
            end
            results_checked++;
        end
        if (quiet)
        begin
            out_ready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 10);
            end
        end
    end

    task automatic reset_model();
        scr_width     = pmpd_pkg::WIDTH_RESET;
        scr_height    = pmpd_pkg::HEIGHT_RESET;
        byte_slot     = 2'd0;
        held_bytes[0] = 8'h00;
        held_bytes[1] = 8'h00;
        cur_col       = COORD_BITS'(pmpd_pkg::CURSOR_X_RESET);
        cur_row       = COORD_BITS'(pmpd_pkg::CURSOR_Y_RESET);
        held_buttons  = 3'd0;
        n_packets     = '0;
        n_dropped     = '0;
        n_aux         = '0;
        n_sync        = '0;
        n_drained     = '0;
    endtask

    task automatic wait_idle();
        while (results_checked != results_due)
        begin
            @(posedge clk);
        end
        repeat (3) @(posedge clk);
    endtask

    task automatic set_screen(input int w, input int h);
        cfg_we    <= 1'b1;
        cfg_index <= pmpd_pkg::REG_SCREEN_WIDTH;
        cfg_data  <= w[SIZE_BITS-1:0];
        @(posedge clk);
        cfg_index <= pmpd_pkg::REG_SCREEN_HEIGHT;
        cfg_data  <= h[SIZE_BITS-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        scr_width  = w[SIZE_BITS-1:0];
        scr_height = h[SIZE_BITS-1:0];
    endtask

    task automatic push_read(input logic full, input logic aux, input logic [7:0] b);
        ctrl_read_t r;
        r.full        = full;
        r.aux         = aux;
        r.data        = b;
        r.pinned      = 1'b0;
        r.pinned_code = pmpd_pkg::EV_NO_DATA;
        pending_reads.push_back(r);
        results_due++;
        if (full)
        begin
            full_reads++;
        end
    endtask

    // Empty reads and drained host bytes may fall between the bytes of a packet.
    task automatic push_mouse_byte(input logic [7:0] b);
        if ($urandom_range(0, 9) == 0)
        begin
            push_read(1'($urandom_range(0, 1)), 1'b0, 8'($urandom));
        end
        push_read(1'b1, 1'b1, b);
    endtask

    task automatic push_packet(input bit drift);
        logic [7:0] flags;
        logic [7:0] mx;
        logic [7:0] my;
        flags = 8'($urandom);
        flags[3] = 1'b1;
        if (drift)
        begin
            flags = {4'b0010, 1'b1, flags[2:0]};
            mx = 8'h7F;
            my = 8'h80;
        end
        else
        begin
            if ($urandom_range(0, 7) != 0)
            begin
                flags[7:6] = 2'b00;
            end
            mx = 8'($urandom);
            my = 8'($urandom);
            if ($urandom_range(0, 1) == 0)
            begin
                mx[6:3] = {4{flags[4]}};
                my[6:3] = {4{flags[5]}};
            end
            if ($urandom_range(0, 9) != 0)
            begin
                mx[7] = flags[4];
            end
            if ($urandom_range(0, 9) != 0)
            begin
                my[7] = flags[5];
            end
        end
        push_mouse_byte(flags);
        push_mouse_byte(mx);
        push_mouse_byte(my);
    endtask

    task automatic run_phase(input int n, input bit drift);
        int target;
        int pick;
        target = full_reads + n;
        while (full_reads < target)
        begin
            pick = drift ? 0 : $urandom_range(0, 9);
            if (pick < 7)
            begin
                push_packet(drift);
            end
            else if (pick < 9)
            begin
                push_read(1'($urandom), 1'($urandom), 8'($urandom));
            end
            else
            begin
                // A packet cut short, so the next one starts out of step.
                repeat ($urandom_range(1, 2)) push_mouse_byte(8'($urandom) | 8'h08);
            end
        end
    endtask

    initial
    begin
        directed_reads = '{
            '{1'b0, 1'b1, 8'hFF, 1'b1, pmpd_pkg::EV_NO_DATA},
            '{1'b1, 1'b0, 8'h00, 1'b1, pmpd_pkg::EV_DRAINED},
            '{1'b1, 1'b0, 8'hFF, 1'b1, pmpd_pkg::EV_DRAINED},
            '{1'b1, 1'b1, 8'h00, 1'b1, pmpd_pkg::EV_SYNC_LOSS},
            '{1'b1, 1'b1, 8'hF7, 1'b1, pmpd_pkg::EV_SYNC_LOSS},
            '{1'b1, 1'b1, 8'h0F, 1'b1, pmpd_pkg::EV_STORED},
            '{1'b1, 1'b1, 8'h7F, 1'b0, pmpd_pkg::EV_NO_DATA},
            '{1'b0, 1'b0, 8'h00, 1'b1, pmpd_pkg::EV_NO_DATA},
            '{1'b1, 1'b0, 8'hAA, 1'b1, pmpd_pkg::EV_DRAINED},
            '{1'b1, 1'b1, 8'h7F, 1'b1, pmpd_pkg::EV_MOVED},
            '{1'b1, 1'b1, 8'h38, 1'b0, pmpd_pkg::EV_NO_DATA},
            '{1'b1, 1'b1, 8'h80, 1'b0, pmpd_pkg::EV_NO_DATA},
            '{1'b1, 1'b1, 8'h80, 1'b1, pmpd_pkg::EV_MOVED},
            '{1'b1, 1'b1, 8'h48, 1'b0, pmpd_pkg::EV_NO_DATA},
            '{1'b1, 1'b1, 8'h00, 1'b0, pmpd_pkg::EV_NO_DATA},
            '{1'b1, 1'b1, 8'h00, 1'b1, pmpd_pkg::EV_OVF_DROP},
            '{1'b1, 1'b1, 8'h18, 1'b0, pmpd_pkg::EV_NO_DATA},
            '{1'b1, 1'b1, 8'h00, 1'b0, pmpd_pkg::EV_NO_DATA},
            '{1'b1, 1'b1, 8'h00, 1'b1, pmpd_pkg::EV_SIGN_DROP},
            '{1'b1, 1'b1, 8'h28, 1'b0, pmpd_pkg::EV_NO_DATA},
            '{1'b1, 1'b1, 8'h7F, 1'b0, pmpd_pkg::EV_NO_DATA},
            '{1'b1, 1'b1, 8'h7F, 1'b1, pmpd_pkg::EV_SIGN_DROP},
            '{1'b1, 1'b1, 8'h08, 1'b0, pmpd_pkg::EV_NO_DATA},
            '{1'b1, 1'b1, 8'h00, 1'b0, pmpd_pkg::EV_NO_DATA},
            '{1'b1, 1'b1, 8'h00, 1'b1, pmpd_pkg::EV_MOVED}
        };
        reset_model();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            pending_reads.push_back(directed_reads[i]);
            results_due++;
        end
        wait_idle();

        set_screen(10, 8);
        run_phase(20, 1'b0);
        wait_idle();
        run_phase(20, 1'b0);
        wait_idle();

        // Walk the cursor to the far corner so that the coordinate cap is reached.
        set_screen(16383, 16383);
        run_phase(215, 1'b1);
        run_phase(10, 1'b0);
        wait_idle();

        set_screen(1, 8192);
        run_phase(25, 1'b0);
        wait_idle();

        set_screen(8192, 1);
        run_phase(25, 1'b0);
        wait_idle();

        set_screen(0, 0);
        run_phase(20, 1'b0);
        wait_idle();

        set_screen($urandom_range(1, 64), $urandom_range(1, 64));
        run_phase(20, 1'b0);
        wait_idle();

        set_screen($urandom_range(1, 8192), $urandom_range(1, 8192));
        run_phase(20, 1'b0);
        wait_idle();

        quiet = 1'b1;
        set_screen(800, 600);
        run_phase(20, 1'b0);
        wait_idle();
        repeat (5) @(posedge clk);

        if (mismatches == 0 && reports_due.size() == 0)
        begin
            $display("** ps2_mouse_packet_decoder: PASSED **");
        end
        else
        begin
            $display("** ps2_mouse_packet_decoder: FAILED **");
        end
        $finish;
    end

    initial
    begin
        #400000;
        $display("** ps2_mouse_packet_decoder: FAILED **");
        $finish;
    end

endmodule
